@@ rtl/core/skc_pkg.sv @@
// Package for the soft-knee compressor gain computer: field widths, fixed-point
// formats, register indexes and the pipeline word types.
// No dependencies.
`timescale 1ns / 1ps

package skc_pkg;

  // Port field widths.
  localparam int LEVEL_W = 23;
  localparam int GAIN_W  = 17;
  localparam int KNEE_W  = 13;
  localparam int RATIO_W = 17;
  localparam int CFG_W   = 17;

  // Default fraction widths of level and gain.
  localparam int LEVEL_FRAC_BITS_DEF = 16;
  localparam int GAIN_FRAC_BITS_DEF  = 16;

  // Internal fixed-point formats.
  localparam int LOG_FB  = 16;  // log2 fraction bits
  localparam int MANT_FB = 30;  // mantissa fraction bits
  localparam int HK_W    = 18;  // half knee in octaves, Q.16
  localparam int ATT_W   = 20;  // attenuation in octaves, Q.16
  localparam int DIV_W   = 57;  // dividend width of the knee divider
  localparam int QUO_W   = 18;  // knee quotient width
  localparam int ISQ_STEPS = MANT_FB + 1;  // root bits resolved per square root
  localparam int REM_W   = 62;  // square root remainder width

  // log2(10)/20 in Q.24.
  localparam logic [21:0] OCT_PER_DB_Q24 = 22'd2786635;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

  // Register reset values.
  localparam logic [KNEE_W-1:0]  KNEE_RESET  = 13'd1536;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd16384;

  // Register indexes.
  localparam logic CFG_KNEE_IDX  = 1'b0;
  localparam logic CFG_RATIO_IDX = 1'b1;

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_KNEE  = 2'd1,
    REGION_ABOVE = 2'd2
  } region_e;

  // Log2 section: normalized mantissa squared once per stage.
  typedef struct packed {
    logic              zero;
    logic signed [5:0] ip;
    logic [30:0]       m;
    logic [LOG_FB-1:0] frac;
  } log_st_t;

  typedef struct packed {
    region_e     region;
    logic [19:0] lgu;
    logic [18:0] d;
  } reg_st_t;

  typedef struct packed {
    region_e     region;
    logic [37:0] dsq;
    logic [36:0] prod;
  } sq_st_t;

  typedef struct packed {
    region_e          region;
    logic [35:0]      plo;
    logic [35:0]      phi;
    logic [ATT_W-1:0] att_a;
  } mul_st_t;

  typedef struct packed {
    region_e          region;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] q;
    logic [ATT_W-1:0] att_a;
  } div_st_t;

  typedef struct packed {
    region_e           region;
    logic [3:0]        n;
    logic [LOG_FB-1:0] f;
    logic [REM_W-1:0]  rem;
    logic [30:0]       r;
  } exp_st_t;

  typedef struct packed {
    region_e           region;
    logic [GAIN_W-1:0] gain;
  } out_t;

endpackage

@@ rtl/core/soft_knee_compressor_gain.sv @@
// Soft-knee compressor gain computer, fully pipelined.
// One word per cycle unless the skid register holds a word and stalls the pipeline.
// Stages: normalize, 16 log2 squarings, region, two multiplies, 18 divider steps,
// and 16 square roots of 31 steps each for 2^-f, then rounding into the output.
// Reset clears all valid bits and loads the knee (6 dB) and ratio (4:1) registers.
// Depends on skc_pkg.
`timescale 1ns / 1ps

module soft_knee_compressor_gain #(
  parameter int LEVEL_FRAC_BITS = skc_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = skc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [skc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [skc_pkg::LEVEL_W-1:0] level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [skc_pkg::GAIN_W-1:0]  gain_o,
  output logic [1:0]                  region_o
);
  import skc_pkg::*;

  localparam int NDIV = QUO_W;
  localparam int NEXP = LOG_FB * ISQ_STEPS;
  localparam logic [40:0] ONE_WIDE = 41'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = ONE_WIDE[GAIN_W-1:0];
  localparam logic [5:0] S_BASE = 6'(MANT_FB - GAIN_FRAC_BITS);

  // Configuration and derived constants.
  logic [KNEE_W-1:0]  kw_q;
  logic [RATIO_W-1:0] ir_q;
  logic [HK_W-1:0]    hk_q;
  logic [16:0]        c_q;
  logic [35:0]        hk_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= KNEE_RESET;
      ir_q <= RATIO_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KNEE_IDX) kw_q <= cfg_data_i[KNEE_W-1:0];
      if (cfg_idx_i == CFG_RATIO_IDX) ir_q <= cfg_data_i[RATIO_W-1:0];
    end
  end

  assign hk_prod = 36'(36'(kw_q) * 36'(OCT_PER_DB_Q24)) + 36'(1 << 16);

  always_ff @(posedge clk_i) begin
    hk_q <= hk_prod[17+HK_W-1:17];
    c_q  <= RATIO_ONE - ((ir_q > RATIO_ONE) ? RATIO_ONE : ir_q);
  end

  // Pipeline advance: everything moves unless the skid register holds a word.
  logic adv;
  logic skid_vld_q;
  assign adv        = !skid_vld_q;
  assign in_ready_o = adv;

  // Log2 section.
  log_st_t log_q   [0:LOG_FB];
  log_st_t log_nxt [0:LOG_FB];
  logic    log_v_q [0:LOG_FB];

  always_comb begin
    logic [4:0] p;
    logic [4:0] sh;
    p = '0;
    for (int b = 0; b < LEVEL_W; b++) begin
      if (level_i[b]) p = 5'(b);
    end
    sh = 5'(MANT_FB) - p;
    log_nxt[0].zero = (level_i == '0);
    log_nxt[0].ip   = 6'(p) - 6'(LEVEL_FRAC_BITS);
    log_nxt[0].m    = 31'(level_i) << sh;
    log_nxt[0].frac = '0;
  end

  for (genvar i = 1; i <= LOG_FB; i++) begin : g_log
    always_comb begin
      logic [61:0] sq;
      logic [31:0] top;
      sq  = 62'(log_q[i-1].m) * 62'(log_q[i-1].m);
      top = sq[61:30];
      log_nxt[i].zero = log_q[i-1].zero;
      log_nxt[i].ip   = log_q[i-1].ip;
      log_nxt[i].m    = top[31] ? top[31:1] : top[30:0];
      log_nxt[i].frac = {log_q[i-1].frac[LOG_FB-2:0], top[31]};
    end
  end

  // Region choice and knee offset.
  reg_st_t rg_q, rg_nxt;
  logic    rg_v_q;

  always_comb begin
    logic signed [21:0] lg;
    logic signed [21:0] hk_s;
    logic signed [21:0] dsum;
    lg   = $signed({log_q[LOG_FB].ip, log_q[LOG_FB].frac});
    hk_s = $signed({4'b0, hk_q});
    dsum = lg + hk_s;
    if (log_q[LOG_FB].zero || (lg < -hk_s)) rg_nxt.region = REGION_BELOW;
    else if (lg < hk_s)                     rg_nxt.region = REGION_KNEE;
    else                                    rg_nxt.region = REGION_ABOVE;
    rg_nxt.lgu = lg[19:0];
    rg_nxt.d   = dsum[18:0];
  end

  // Squares and products.
  sq_st_t  sq_q, sq_nxt;
  logic    sq_v_q;
  mul_st_t mu_q, mu_nxt;
  logic    mu_v_q;

  always_comb begin
    sq_nxt.region = rg_q.region;
    sq_nxt.dsq    = 38'(rg_q.d) * 38'(rg_q.d);
    sq_nxt.prod   = 37'(c_q) * 37'(rg_q.lgu);
  end

  always_comb begin
    logic [37:0] rnd;
    rnd = 38'(sq_q.prod) + 38'(1 << 15);
    mu_nxt.region = sq_q.region;
    mu_nxt.plo    = 36'(c_q) * 36'(sq_q.dsq[18:0]);
    mu_nxt.phi    = 36'(c_q) * 36'(sq_q.dsq[37:19]);
    mu_nxt.att_a  = rnd[16+ATT_W-1:16];
  end

  // Knee divider: rounded quotient of c*d*d by hk*2^18, one bit per stage.
  div_st_t div_q   [0:NDIV];
  div_st_t div_nxt [0:NDIV];
  logic    div_v_q [0:NDIV];

  always_comb begin
    div_nxt[0].region = mu_q.region;
    div_nxt[0].rem    = (DIV_W'(mu_q.phi) << 19) + DIV_W'(mu_q.plo) + (DIV_W'(hk_q) << 17);
    div_nxt[0].q      = '0;
    div_nxt[0].att_a  = mu_q.att_a;
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int K = NDIV - j;
    always_comb begin
      logic [DIV_W-1:0] dv;
      logic             ge;
      dv = DIV_W'(hk_q) << (18 + K);
      ge = (div_q[j-1].rem >= dv);
      div_nxt[j]       = div_q[j-1];
      div_nxt[j].rem   = ge ? div_q[j-1].rem - dv : div_q[j-1].rem;
      div_nxt[j].q     = div_q[j-1].q | (QUO_W'(ge) << K);
    end
  end

  // 2^-f by repeated square roots, lsb of f first, one root bit per stage.
  exp_st_t ex_q   [0:NEXP];
  exp_st_t ex_nxt [0:NEXP];
  logic    ex_v_q [0:NEXP];

  always_comb begin
    logic [ATT_W-1:0] att;
    att = (div_q[NDIV].region == REGION_KNEE) ? ATT_W'(div_q[NDIV].q) : div_q[NDIV].att_a;
    ex_nxt[0].region = div_q[NDIV].region;
    ex_nxt[0].n      = att[ATT_W-1:LOG_FB];
    ex_nxt[0].f      = att[LOG_FB-1:0];
    ex_nxt[0].rem    = '0;
    ex_nxt[0].r      = 31'(1) << MANT_FB;
  end

  for (genvar j = 1; j <= NEXP; j++) begin : g_exp
    localparam int RND = (j - 1) / ISQ_STEPS;
    localparam int K   = MANT_FB - ((j - 1) % ISQ_STEPS);
    always_comb begin
      logic [30:0]      y;
      logic [REM_W-1:0] rem_in;
      logic [30:0]      r_in;
      logic [REM_W-1:0] t;
      logic             ge;
      if (K == MANT_FB) begin
        y      = ex_q[j-1].f[RND] ? (ex_q[j-1].r >> 1) : ex_q[j-1].r;
        rem_in = REM_W'(y) << MANT_FB;
        r_in   = '0;
      end else begin
        y      = ex_q[j-1].r;
        rem_in = ex_q[j-1].rem;
        r_in   = ex_q[j-1].r;
      end
      t  = (REM_W'(r_in) << (K + 1)) + (REM_W'(1) << (2 * K));
      ge = (rem_in >= t);
      ex_nxt[j]     = ex_q[j-1];
      ex_nxt[j].rem = ge ? rem_in - t : rem_in;
      ex_nxt[j].r   = ge ? (r_in | (31'(1) << K)) : r_in;
    end
  end

  // Final scaling by 2^-n with rounding.
  out_t res;
  always_comb begin
    logic [5:0]  s;
    logic [40:0] sum;
    logic [40:0] shd;
    s   = S_BASE + 6'(ex_q[NEXP].n);
    sum = 41'(ex_q[NEXP].r) + (41'(1) << (s - 6'd1));
    shd = sum >> s;
    res.region = ex_q[NEXP].region;
    res.gain   = (ex_q[NEXP].region == REGION_BELOW) ? GAIN_ONE : shd[GAIN_W-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LOG_FB; i++) log_v_q[i] <= 1'b0;
      rg_v_q <= 1'b0;
      sq_v_q <= 1'b0;
      mu_v_q <= 1'b0;
      for (int i = 0; i <= NDIV; i++) div_v_q[i] <= 1'b0;
      for (int i = 0; i <= NEXP; i++) ex_v_q[i] <= 1'b0;
    end else if (adv) begin
      log_v_q[0] <= in_valid_i;
      for (int i = 1; i <= LOG_FB; i++) log_v_q[i] <= log_v_q[i-1];
      rg_v_q     <= log_v_q[LOG_FB];
      sq_v_q     <= rg_v_q;
      mu_v_q     <= sq_v_q;
      div_v_q[0] <= mu_v_q;
      for (int i = 1; i <= NDIV; i++) div_v_q[i] <= div_v_q[i-1];
      ex_v_q[0]  <= div_v_q[NDIV];
      for (int i = 1; i <= NEXP; i++) ex_v_q[i] <= ex_v_q[i-1];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= LOG_FB; i++) log_q[i] <= log_nxt[i];
      rg_q <= rg_nxt;
      sq_q <= sq_nxt;
      mu_q <= mu_nxt;
      for (int i = 0; i <= NDIV; i++) div_q[i] <= div_nxt[i];
      for (int i = 0; i <= NEXP; i++) ex_q[i] <= ex_nxt[i];
    end
  end

  // Output register with a skid word behind it.
  out_t out_q, skid_q;
  logic out_vld_q;
  logic push, pop;
  assign push = adv && ex_v_q[NEXP];
  assign pop  = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign gain_o      = out_q.gain;
  assign region_o    = out_q.region;

  // A word in the skid register always has one ahead of it.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held while output register empty");

  // Words below the knee leave with unity gain.
  a_below_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.region == REGION_BELOW) |-> (out_q.gain == GAIN_ONE))
    else $error("gain below knee is not unity");

  // The knee attenuation never exceeds the half knee.
  a_knee_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[NDIV] && div_q[NDIV].region == REGION_KNEE) |-> (div_q[NDIV].q <= hk_q))
    else $error("knee quotient out of range");

  // The pipeline only stops with both output slots full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $past(out_vld_q))
    else $error("stall without a full output register");

endmodule
